### rtl/indexed_list_insert_delete_top_macros.svh
// Assertion helpers shared by the list RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef INDEXED_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_TOP_MACROS_SVH

// Same-cycle implication.
`define ILID_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ILID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ilid_pkg.sv
package ilid_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 6;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } ilid_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ilid_status_e;

  typedef struct packed {
    ilid_op_e                  opcode;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } ilid_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  removed_value;
    ilid_status_e              status;
    logic [COUNT_W-1:0]        entry_count;
  } ilid_res_t;

  // Control broadcast to every cell in the row.
  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic [IDX_W-1:0]  pos;
  } ilid_ctrl_t;

endpackage

### rtl/ilid_cell.sv
module ilid_cell import ilid_pkg::*; (
  input  logic                      clk_i,
  input  ilid_ctrl_t                ctrl_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic signed [DATA_W-1:0]  value_i,
  input  logic signed [DATA_W-1:0]  left_i,
  input  logic signed [DATA_W-1:0]  right_i,
  output logic signed [DATA_W-1:0]  data_o,
  output logic signed [DATA_W-1:0]  tap_o
);

  logic signed [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      // Take the neighbor below past the insert point, load the new value at it.
      if (idx_i > ctrl_i.pos) begin
        data_d = left_i;
      end else if (idx_i == ctrl_i.pos) begin
        data_d = value_i;
      end
    end else if (ctrl_i.shift_down) begin
      if (idx_i >= ctrl_i.pos) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (idx_i == ctrl_i.pos) ? data_q : '0;

endmodule

### rtl/ilid_row.sv
module ilid_row import ilid_pkg::*; (
  input  logic                      clk_i,
  input  ilid_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0]  value_i,
  output logic signed [DATA_W-1:0]  sel_data_o
);

  logic signed [DATA_W-1:0] data [CAPACITY];
  logic signed [DATA_W-1:0] tap  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    ilid_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (IDX_W'(i)),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[i]),
      .tap_o   (tap[i])
    );
  end

  // Only the addressed cell drives a nonzero tap; merge them.
  always_comb begin
    sel_data_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_data_o = sel_data_o | tap[i];
    end
  end

endmodule

### rtl/indexed_list_insert_delete_top.sv
// Ordered list of up to 64 signed 32-bit entries with insert and delete at an index.
// Request channel: in_valid_i / in_ready_o carry in_req_i (opcode, position, value).
//   Insert places value at position and moves later entries up; a position at or
//   past the count appends. Delete removes the entry at position and moves later
//   entries down.
// Result channel: out_valid_o / out_ready_i carry out_res_o (removed_value, status,
//   entry_count). Every request yields exactly one result.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; each entry lives in its own
//   cell, and the whole row of cells shifts together in the same cycle.
// Errors: delete at or past the count returns -1 with a range status; insert into
//   a full list returns -1 with a full status. The list is left unchanged.
// Stall: a single output register holds the result while out_ready_i is low, and
//   in_ready_o drops until that result is taken.
// Reset: clears the entry count and the output valid; entry contents are not
//   cleared, since only entries below the count are ever read.
`include "indexed_list_insert_delete_top_macros.svh"

module indexed_list_insert_delete_top import ilid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ilid_req_t  in_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ilid_res_t  out_res_o
);

  logic [COUNT_W-1:0]       count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  ilid_res_t                res_q, res_d;
  ilid_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] sel_data;
  logic                     accept, is_del, del_ok, ins_ok;
  logic [COUNT_W-1:0]       pos_ext, pos_eff;

  // Accept whenever the output register is empty or draining this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_del  = (in_req_i.opcode == OP_DELETE);
  assign pos_ext = COUNT_W'(in_req_i.position);
  assign del_ok  = is_del && (pos_ext < count_q);
  assign ins_ok  = !is_del && (count_q < COUNT_W'(CAPACITY));
  // Clamp insert position to the end of the list (append).
  assign pos_eff = (pos_ext > count_q) ? count_q : pos_ext;

  always_comb begin
    ctrl.shift_up   = accept && ins_ok;
    ctrl.shift_down = accept && del_ok;
    ctrl.pos        = is_del ? IDX_W'(in_req_i.position) : pos_eff[IDX_W-1:0];
  end

  ilid_row u_row (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .value_i    (in_req_i.value),
    .sel_data_o (sel_data)
  );

  always_comb begin
    count_d     = count_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      if (is_del) begin
        if (del_ok) begin
          count_d             = count_q - COUNT_W'(1);
          res_d.removed_value = sel_data;
          res_d.status        = ST_OK;
        end else begin
          res_d.removed_value = -32'sd1;
          res_d.status        = ST_RANGE;
        end
      end else begin
        if (ins_ok) begin
          count_d             = count_q + COUNT_W'(1);
          res_d.removed_value = '0;
          res_d.status        = ST_OK;
        end else begin
          res_d.removed_value = -32'sd1;
          res_d.status        = ST_FULL;
        end
      end
      res_d.entry_count = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  `ILID_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= COUNT_W'(CAPACITY))
  `ILID_ASSERT_IMPL(a_one_shift, ctrl.shift_up, !ctrl.shift_down)
  `ILID_ASSERT_NEXT(a_del_count, ctrl.shift_down, count_q == $past(count_q) - COUNT_W'(1))
  `ILID_ASSERT_NEXT(a_ins_count, ctrl.shift_up, count_q == $past(count_q) + COUNT_W'(1))
  `ILID_ASSERT_IMPL(a_stall_ready, !in_ready_o, out_valid_q)

endmodule
